>>> hw/rtl/ajb_pkg.sv
// Shared types, constants and helper functions for the audio jitter buffer.
`default_nettype none
package ajb_pkg;
    localparam int JITTER_SLOTS    = 16;
    localparam int SLOT_BITS       = $clog2(JITTER_SLOTS);
    localparam int MAX_BLOCK_WORDS = 256;
    localparam int WORD_BITS       = $clog2(MAX_BLOCK_WORDS);
    localparam int STORE_DEPTH     = JITTER_SLOTS * MAX_BLOCK_WORDS;
    localparam int BW_BITS         = 13;

    localparam logic [2:0] CMD_RX_HDR      = 3'd0;
    localparam logic [2:0] CMD_RX_SAMPLE   = 3'd1;
    localparam logic [2:0] CMD_PULL_START  = 3'd2;
    localparam logic [2:0] CMD_PULL_SAMPLE = 3'd3;
    localparam logic [2:0] CMD_TICK        = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNDERRUN = 2'd1;
    localparam logic [1:0] ST_DOWN     = 2'd2;

    localparam logic [1:0] SRC_SLOT   = 2'd0;
    localparam logic [1:0] SRC_LAST   = 2'd1;
    localparam logic [1:0] SRC_SILENT = 2'd2;

    localparam logic [2:0] REG_LINK_ENABLE   = 3'd0;
    localparam logic [2:0] REG_BLOCK_FRAMES  = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_MAGIC_WORD    = 3'd3;
    localparam logic [2:0] REG_VERSION_WORD  = 3'd4;
    localparam logic [2:0] REG_LINK_DOWN_MS  = 3'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] seq;
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] frames;
        logic [15:0] channels;
        logic        length_ok;
        logic [31:0] sample;
        logic [7:0]  word_index;
    } in_t;

    typedef struct packed {
        logic        is_sample;
        logic [1:0]  status;
        logic [31:0] sample_out;
        logic        link_down;
        logic [31:0] underrun_count;
        logic [31:0] bad_packet_count;
        logic [31:0] received_count;
    } out_t;

    typedef struct packed {
        logic        link_enable;
        logic [8:0]  block_frames;
        logic [3:0]  channel_count;
        logic [31:0] magic_word;
        logic [15:0] version_word;
        logic [15:0] link_down_ms;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_HDR_GOOD,
        OP_HDR_BAD,
        OP_RX_WORD,
        OP_PULL,
        OP_PULL_WORD,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] seq;
        logic [31:0] sample;
        logic [7:0]  word_index;
    } qent_t;

    typedef struct packed {
        logic copy_active;
        logic usable;
        logic pop;
    } back_status_t;

    function automatic logic [BW_BITS-1:0] block_words(input cfg_t c);
        block_words = BW_BITS'({4'd0, c.block_frames} * {9'd0, c.channel_count});
    endfunction

    function automatic logic link_usable(input cfg_t c);
        link_usable = c.link_enable && (c.block_frames != 9'd0) &&
                      (c.channel_count != 4'd0) && (c.channel_count <= 4'd8) &&
                      (block_words(c) <= BW_BITS'(MAX_BLOCK_WORDS));
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/ajb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ajb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/ajb_front.sv
// Front end: accepts input beats, classifies them and queues the work.
`default_nettype none
module ajb_front
    import ajb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire in_t   in_data,
    input  wire cfg_t  cfg,
    input  wire logic  pop,
    output logic       q_valid,
    output qent_t      q_data
);
    qent_t      ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       push;
    qent_t      ent;
    logic       use_link;
    logic       hdr_match;

    always_comb
    begin
        use_link  = link_usable(cfg);
        hdr_match = in_data.length_ok && (in_data.magic == cfg.magic_word) &&
                    (in_data.version == cfg.version_word) &&
                    (in_data.frames == {7'd0, cfg.block_frames}) &&
                    (in_data.channels == {12'd0, cfg.channel_count});
        ent.seq        = in_data.seq;
        ent.sample     = in_data.sample;
        ent.word_index = in_data.word_index;
        ent.op         = OP_TICK;
        keep           = 1'b0;
        unique case (in_data.command)
            CMD_RX_HDR:
            begin
                keep   = use_link;
                ent.op = hdr_match ? OP_HDR_GOOD : OP_HDR_BAD;
            end
            CMD_RX_SAMPLE:
            begin
                // Words past the end of the block are dropped here.
                keep   = use_link && ({5'd0, in_data.word_index} < block_words(cfg));
                ent.op = OP_RX_WORD;
            end
            CMD_PULL_START:
            begin
                keep   = 1'b1;
                ent.op = OP_PULL;
            end
            CMD_PULL_SAMPLE:
            begin
                keep   = 1'b1;
                ent.op = OP_PULL_WORD;
            end
            CMD_TICK:
            begin
                keep   = use_link;
                ent.op = OP_TICK;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/ajb_back.sv
// Back end: configuration, buffer state, block stores and the result register.
`default_nettype none
module ajb_back
    import ajb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        q_valid,
    input  wire qent_t       q_data,
    output cfg_t             cfg,
    output back_status_t     st,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RSP  = 3'b010,
        S_COPY = 3'b100
    } state_t;

    cfg_t                cfg_reg, cfg_next;
    logic [31:0]         tag_reg [JITTER_SLOTS];
    logic [31:0]         tag_next [JITTER_SLOTS];
    logic [JITTER_SLOTS-1:0] tag_valid_reg, tag_valid_next;
    logic                have_last_reg, have_last_next;
    logic [15:0]         miss_reg, miss_next;
    logic                ld_reg, ld_next;
    logic [15:0]         ms_reg, ms_next;
    logic                acc_reg, acc_next;
    logic [31:0]         pend_reg, pend_next;
    logic [1:0]          src_reg, src_next;
    logic [SLOT_BITS-1:0] pslot_reg, pslot_next;
    logic [1:0]          pstat_reg, pstat_next;
    logic [31:0]         und_reg, und_next;
    logic [31:0]         bad_reg, bad_next;
    logic [31:0]         rcv_reg, rcv_next;
    state_t              state_reg, state_next;
    logic [WORD_BITS:0]  copy_cnt_reg, copy_cnt_next;
    logic [1:0]          sel_reg, sel_next;
    logic                rsp_smp_reg, rsp_smp_next;
    logic                rsp_copy_reg, rsp_copy_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_reg, out_next;

    logic                use_link;
    logic [BW_BITS-1:0]  w;
    logic                take;
    logic                is_result;
    logic [SLOT_BITS-1:0] s;
    logic                hit;
    logic [15:0]         ms_inc;
    logic [31:0]         word;

    logic                             slot_we;
    logic [$clog2(STORE_DEPTH)-1:0]   slot_waddr, slot_raddr;
    logic [31:0]                      slot_rdata;
    logic                             last_we;
    logic [WORD_BITS-1:0]             last_waddr;
    logic [31:0]                      last_rdata;

    assign cfg      = cfg_reg;
    assign use_link = link_usable(cfg_reg);
    assign w        = block_words(cfg_reg);
    assign is_result = (q_data.op == OP_PULL) || (q_data.op == OP_PULL_WORD);
    assign take     = (state_reg == S_IDLE) && q_valid && !(is_result && out_valid_reg);
    assign s        = q_data.seq[SLOT_BITS-1:0];
    assign hit      = tag_valid_reg[s] && (tag_reg[s] == q_data.seq + 32'd1);
    assign ms_inc   = (ms_reg != 16'hFFFF) ? ms_reg + 16'd1 : ms_reg;

    assign st.copy_active = (state_reg == S_COPY);
    assign st.usable      = use_link;
    assign st.pop         = take;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Store writes come from received words; reads serve pulls and the block copy.
    assign slot_we    = take && (q_data.op == OP_RX_WORD) && acc_reg;
    assign slot_waddr = {pend_reg[SLOT_BITS-1:0], q_data.word_index};
    assign slot_raddr = (state_reg == S_COPY) ?
                        {pslot_reg, copy_cnt_reg[WORD_BITS-1:0]} :
                        {pslot_reg, q_data.word_index};
    assign last_we    = (state_reg == S_COPY) && (copy_cnt_reg != '0);
    assign last_waddr = copy_cnt_reg[WORD_BITS-1:0] - WORD_BITS'(1);

    ajb_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (q_data.sample),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ajb_ram #(.WIDTH(32), .DEPTH(MAX_BLOCK_WORDS)) u_last_ram (
        .clk   (clk),
        .we    (last_we),
        .waddr (last_waddr),
        .wdata (slot_rdata),
        .raddr (q_data.word_index),
        .rdata (last_rdata)
    );

    always_comb
    begin
        unique case (sel_reg)
            SRC_SLOT: word = slot_rdata;
            SRC_LAST: word = last_rdata;
            default:  word = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg_next       = cfg_reg;
        tag_next       = tag_reg;
        tag_valid_next = tag_valid_reg;
        have_last_next = have_last_reg;
        miss_next      = miss_reg;
        ld_next        = ld_reg;
        ms_next        = ms_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        src_next       = src_reg;
        pslot_next     = pslot_reg;
        pstat_next     = pstat_reg;
        und_next       = und_reg;
        bad_next       = bad_reg;
        rcv_next       = rcv_reg;
        state_next     = state_reg;
        copy_cnt_next  = copy_cnt_reg;
        sel_next       = sel_reg;
        rsp_smp_next   = rsp_smp_reg;
        rsp_copy_next  = rsp_copy_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (q_data.op)
                        OP_HDR_GOOD:
                        begin
                            tag_next[s]       = 32'd0;
                            tag_valid_next[s] = 1'b0;
                            pend_next         = q_data.seq;
                            acc_next          = 1'b1;
                        end
                        OP_HDR_BAD:
                        begin
                            bad_next = bad_reg + 32'd1;
                            acc_next = 1'b0;
                        end
                        OP_RX_WORD:
                        begin
                            if (acc_reg && ({5'd0, q_data.word_index} == w - BW_BITS'(1)))
                            begin
                                tag_next[pend_reg[SLOT_BITS-1:0]]       = pend_reg + 32'd1;
                                tag_valid_next[pend_reg[SLOT_BITS-1:0]] = 1'b1;
                                rcv_next = rcv_reg + 32'd1;
                                ms_next  = 16'd0;
                                ld_next  = 1'b0;
                                acc_next = 1'b0;
                            end
                        end
                        OP_TICK:
                        begin
                            ms_next = ms_inc;
                            if (ms_inc > cfg_reg.link_down_ms)
                            begin
                                ld_next = 1'b1;
                            end
                        end
                        OP_PULL:
                        begin
                            rsp_smp_next  = 1'b0;
                            rsp_copy_next = 1'b0;
                            sel_next      = SRC_SILENT;
                            state_next    = S_RSP;
                            if (!use_link)
                            begin
                                src_next   = SRC_SILENT;
                                pstat_next = ST_DOWN;
                            end
                            else if (hit)
                            begin
                                have_last_next = 1'b1;
                                miss_next      = 16'd0;
                                src_next       = SRC_SLOT;
                                pslot_next     = s;
                                pstat_next     = ST_OK;
                                rsp_copy_next  = 1'b1;
                                copy_cnt_next  = '0;
                            end
                            else if (ld_reg)
                            begin
                                if (miss_reg != 16'hFFFF)
                                begin
                                    miss_next = miss_reg + 16'd1;
                                end
                                src_next   = SRC_SILENT;
                                pstat_next = ST_DOWN;
                            end
                            else
                            begin
                                und_next = und_reg + 32'd1;
                                src_next = (miss_reg == 16'd0 && have_last_reg) ?
                                           SRC_LAST : SRC_SILENT;
                                if (miss_reg != 16'hFFFF)
                                begin
                                    miss_next = miss_reg + 16'd1;
                                end
                                pstat_next = ST_UNDERRUN;
                            end
                        end
                        OP_PULL_WORD:
                        begin
                            rsp_smp_next  = 1'b1;
                            rsp_copy_next = 1'b0;
                            sel_next   = ({5'd0, q_data.word_index} < w) ? src_reg : SRC_SILENT;
                            state_next = S_RSP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RSP:
            begin
                out_valid_next            = 1'b1;
                out_next.is_sample        = rsp_smp_reg;
                out_next.status           = pstat_reg;
                out_next.sample_out       = word;
                out_next.link_down        = ld_reg;
                out_next.underrun_count   = und_reg;
                out_next.bad_packet_count = bad_reg;
                out_next.received_count   = rcv_reg;
                state_next = rsp_copy_reg ? S_COPY : S_IDLE;
            end
            S_COPY:
            begin
                // One word read and the previous one written each cycle.
                copy_cnt_next = copy_cnt_reg + 1'b1;
                if (copy_cnt_reg[WORD_BITS])
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINK_ENABLE:
                begin
                    if (cfg_data[0] && !cfg_reg.link_enable)
                    begin
                        tag_valid_next = '0;
                        for (int i = 0; i < JITTER_SLOTS; i++)
                        begin
                            tag_next[i] = 32'd0;
                        end
                        have_last_next = 1'b0;
                        miss_next      = 16'd0;
                        ld_next        = 1'b0;
                        ms_next        = 16'd0;
                        acc_next       = 1'b0;
                        src_next       = SRC_SILENT;
                        pstat_next     = ST_DOWN;
                        und_next       = 32'd0;
                        bad_next       = 32'd0;
                        rcv_next       = 32'd0;
                    end
                    cfg_next.link_enable = cfg_data[0];
                end
                REG_BLOCK_FRAMES:  cfg_next.block_frames  = cfg_data[8:0];
                REG_CHANNEL_COUNT: cfg_next.channel_count = cfg_data[3:0];
                REG_MAGIC_WORD:    cfg_next.magic_word    = cfg_data;
                REG_VERSION_WORD:  cfg_next.version_word  = cfg_data[15:0];
                REG_LINK_DOWN_MS:  cfg_next.link_down_ms  = cfg_data[15:0];
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_enable   <= 1'b0;
            cfg_reg.block_frames  <= 9'd64;
            cfg_reg.channel_count <= 4'd2;
            cfg_reg.magic_word    <= 32'd0;
            cfg_reg.version_word  <= 16'd0;
            cfg_reg.link_down_ms  <= 16'd500;
            for (int i = 0; i < JITTER_SLOTS; i++)
            begin
                tag_reg[i] <= 32'd0;
            end
            tag_valid_reg <= '0;
            have_last_reg <= 1'b0;
            miss_reg      <= 16'd0;
            ld_reg        <= 1'b0;
            ms_reg        <= 16'd0;
            acc_reg       <= 1'b0;
            pend_reg      <= 32'd0;
            src_reg       <= SRC_SILENT;
            pslot_reg     <= '0;
            pstat_reg     <= ST_DOWN;
            und_reg       <= 32'd0;
            bad_reg       <= 32'd0;
            rcv_reg       <= 32'd0;
            state_reg     <= S_IDLE;
            copy_cnt_reg  <= '0;
            sel_reg       <= SRC_SILENT;
            rsp_smp_reg   <= 1'b0;
            rsp_copy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            tag_reg       <= tag_next;
            tag_valid_reg <= tag_valid_next;
            have_last_reg <= have_last_next;
            miss_reg      <= miss_next;
            ld_reg        <= ld_next;
            ms_reg        <= ms_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            src_reg       <= src_next;
            pslot_reg     <= pslot_next;
            pstat_reg     <= pstat_next;
            und_reg       <= und_next;
            bad_reg       <= bad_next;
            rcv_reg       <= rcv_next;
            state_reg     <= state_next;
            copy_cnt_reg  <= copy_cnt_next;
            sel_reg       <= sel_next;
            rsp_smp_reg   <= rsp_smp_next;
            rsp_copy_reg  <= rsp_copy_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/audio_jitter_buffer_concealment.sv
// Receive jitter buffer with loss concealment for sequence-numbered audio blocks.
// Input beats (in_valid/in_stall/in_data) carry rx headers, rx sample words,
// pull starts, pull samples and millisecond ticks. Output beats
// (out_valid/out_stall/out_data) carry one result per pull start or pull sample.
// Headers, sample words and ticks are handled in the back end's idle state; pulls
// also pass through the response state (the block store read is registered) and
// their result reaches the output register after leaving the two-beat front queue.
// A pull start that hits a slot then copies the block into the last-good store,
// one word a cycle over the single store read port, before the next item is taken.
// The front queue accepts while it has room, so input is taken even while a
// result waits in the output register; when out_stall is held the output beat
// holds, items without a result keep draining, and the next pull waits in the
// queue until the held beat is taken. Reset leaves the link closed, the slots empty
// and the pull status link down. The user writes configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
`default_nettype none
module audio_jitter_buffer_concealment
    import ajb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    cfg_t         cfg;
    back_status_t st;
    logic         q_valid;
    qent_t        q_data;

    ajb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg),
        .pop      (st.pop),
        .q_valid  (q_valid),
        .q_data   (q_data)
    );

    ajb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .cfg       (cfg),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // Nothing leaves the queue while a block copy holds the store read port.
    a_no_pop_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        st.copy_active |-> !st.pop)
        else $error("item taken during block copy");

    // A copy starts only behind an ok status beat.
    a_copy_after_ok: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(st.copy_active) |-> out_valid && !out_data.is_sample &&
                                  out_data.status == ST_OK)
        else $error("block copy without a hit");

    // With the link unusable every status beat reports link down.
    a_down_when_unusable: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && !out_data.is_sample && !st.usable |->
            out_data.status == ST_DOWN)
        else $error("status beat not link down while link unusable");
`endif
endmodule
`default_nettype wire
